// ----- hw/rtl/bilinear_height_sampler_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear height sampler
// Concurrent assertion wrappers, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_HEIGHT_SAMPLER_MACROS_SVH
`define BILINEAR_HEIGHT_SAMPLER_MACROS_SVH
`ifndef ASSERT_OFF
`define BHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/bhs_pkg.sv -----
// ----------------------------------------------------------------------------
// Bilinear height sampler package
// Widths, register indexes and request codes shared by the sampler.
// ----------------------------------------------------------------------------
package bhs_pkg;
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned CoordW = 24;
  localparam int unsigned ProdFrac = 24;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0, REG_ORIGIN_Y = 3'd1, REG_INV_X = 3'd2,
    REG_INV_Y = 3'd3, REG_MAP_W = 3'd4, REG_MAP_H = 3'd5
  } reg_idx_t;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic [23:0] origin_x;
    logic [23:0] origin_y;
    logic [23:0] inv_x;
    logic [23:0] inv_y;
    logic [8:0]  map_w;
    logic [8:0]  map_h;
  } cfg_t;
endpackage

// ----- hw/rtl/bhs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with enable, registered read data.
// ----------------------------------------------------------------------------
module bhs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/bhs_axis_map.sv -----
// ----------------------------------------------------------------------------
// Texel-space coordinate mapper
// Two-stage per-axis map: subtract origin, scale, clamp into the map.
// ----------------------------------------------------------------------------
module bhs_axis_map #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned MAXS = 256
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [23:0]                          q,
  input  logic [23:0]                          org,
  input  logic [23:0]                          inv,
  input  logic [8:0]                           size,
  output logic [$clog2(MAXS)+FRAC_BITS-1:0]    s
);
  import bhs_pkg::*;
  localparam int unsigned IW = $clog2(MAXS);
  localparam int unsigned SW = IW + FRAC_BITS;
  localparam int unsigned SH = ProdFrac - FRAC_BITS;

  logic signed [24:0] d;
  logic signed [49:0] p_r;
  logic [8:0]         size_r;
  logic [8:0]         sz;
  logic [49:0]        sh;
  logic [49:0]        lim;

  // stage 1: difference and scale product
  assign d = $signed({q[23], q}) - $signed({org[23], org});
  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= 50'(d * $signed({1'b0, inv}));
      size_r <= size;
    end
  end

  // stage 2: truncate and clamp
  always_comb begin
    if (size_r < 9'd2) sz = 9'd2;
    else if ({23'd0, size_r} > 32'(MAXS)) sz = 9'(MAXS);
    else sz = size_r;
    lim = 50'(sz - 9'd1) << FRAC_BITS;
    sh  = 50'($unsigned(p_r) >> SH);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (p_r[49]) s <= '0;
      else if (sh >= lim) s <= SW'(lim - (50'd1 << (FRAC_BITS - 1)));
      else s <= SW'(sh);
    end
  end
endmodule

// ----- hw/rtl/bilinear_height_sampler.sv -----
// Pipeline: a query's result passes register stages map 2, memory 1, blend 2
// (the first is loaded at its accepting edge).
// Throughput: one item per cycle unless a held result stalls every stage; set by
// the four-bank height store, each bank read once per cycle. A write returns
// nothing and reaches the store at the read stage, so items keep their order.
// Reset: synchronous active-low clears config and valid bits, not data or store.
// ----------------------------------------------------------------------------
// Bilinear height sampler top level
// Height map store, per-axis mapping, four-bank fetch and bilinear blend.
// ----------------------------------------------------------------------------
`include "bilinear_height_sampler_macros.svh"
module bilinear_height_sampler #(
  parameter int unsigned MAX_WIDTH  = bhs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bhs_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned FRAC_BITS  = bhs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,      // req_type
  input  logic [71:0] in_tdata,      // texel_address[15:0], texel_value[23:16],
                                     // query_x[47:24], query_y[71:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // sampled_height[15:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bhs_pkg::*;
  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned BXW = XW - 1;
  localparam int unsigned BYW = YW - 1;
  localparam int unsigned BD  = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int unsigned BAW = $clog2(BD);
  localparam int unsigned ONE = 1 << FRAC_BITS;
  localparam int unsigned SUMW = 8 + 2 * FRAC_BITS + 2;

  cfg_t cfg_r;
  logic [2:0] ridx;
  logic       pipe_en;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{origin_x: 24'd0, origin_y: 24'd0, inv_x: 24'd65536,
                 inv_y: 24'd65536, map_w: 9'd256, map_h: 9'd256};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        REG_ORIGIN_X: cfg_r.origin_x <= cfg_pwdata[23:0];
        REG_ORIGIN_Y: cfg_r.origin_y <= cfg_pwdata[23:0];
        REG_INV_X:    cfg_r.inv_x    <= cfg_pwdata[23:0];
        REG_INV_Y:    cfg_r.inv_y    <= cfg_pwdata[23:0];
        REG_MAP_W:    cfg_r.map_w    <= cfg_pwdata[8:0];
        REG_MAP_H:    cfg_r.map_h    <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (ridx)
      REG_ORIGIN_X: cfg_prdata = {8'd0, cfg_r.origin_x};
      REG_ORIGIN_Y: cfg_prdata = {8'd0, cfg_r.origin_y};
      REG_INV_X:    cfg_prdata = {8'd0, cfg_r.inv_x};
      REG_INV_Y:    cfg_prdata = {8'd0, cfg_r.inv_y};
      REG_MAP_W:    cfg_prdata = {23'd0, cfg_r.map_w};
      REG_MAP_H:    cfg_prdata = {23'd0, cfg_r.map_h};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // pipeline advances unless a held result blocks it
  logic [4:0] v_r;           // query valid per stage
  assign pipe_en   = !(out_tvalid && !out_tready);
  assign in_tready = pipe_en;
  logic acc;
  assign acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (pipe_en) v_r <= {v_r[3:0], acc && in_tuser == REQ_QUERY};
  end

  // stages 1-2: coordinate mapping
  logic [XW+FRAC_BITS-1:0] sx;
  logic [YW+FRAC_BITS-1:0] sy;
  bhs_axis_map #(.FRAC_BITS(FRAC_BITS), .MAXS(MAX_WIDTH)) u_map_x (
    .clk(clk), .en(pipe_en), .q(in_tdata[47:24]), .org(cfg_r.origin_x),
    .inv(cfg_r.inv_x), .size(cfg_r.map_w), .s(sx));
  bhs_axis_map #(.FRAC_BITS(FRAC_BITS), .MAXS(MAX_HEIGHT)) u_map_y (
    .clk(clk), .en(pipe_en), .q(in_tdata[71:48]), .org(cfg_r.origin_y),
    .inv(cfg_r.inv_y), .size(cfg_r.map_h), .s(sy));

  // texel writes travel alongside the mapping stages and land at the read stage
  logic [15:0] waddr_in;
  logic        wr_ok;
  logic [1:0]  wv_r;
  logic [15:0] wa1_r, wa2_r;
  logic [7:0]  wd1_r, wd2_r;
  logic [XW-1:0] wcol;
  logic [YW-1:0] wrow;
  assign waddr_in = in_tdata[15:0];
  assign wr_ok = acc && in_tuser == REQ_WRITE &&
                 {16'd0, waddr_in} < 32'(MAX_WIDTH * MAX_HEIGHT);
  always_ff @(posedge clk) begin
    if (!rst_n) wv_r <= '0;
    else if (pipe_en) wv_r <= {wv_r[0], wr_ok};
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      wa1_r <= waddr_in;
      wd1_r <= in_tdata[23:16];
      wa2_r <= wa1_r;
      wd2_r <= wd1_r;
    end
  end

  // bank by column and row parity
  assign wcol = XW'(wa2_r % MAX_WIDTH);
  assign wrow = YW'(wa2_r / MAX_WIDTH);

  // stage 3: four-bank read of the 2x2 neighbourhood
  logic [XW-1:0] px, px1;
  logic [YW-1:0] py, py1;
  logic [7:0]    bank_q [4];
  logic [FRAC_BITS-1:0] wx_r, wy_r, wy2_r;
  logic          pxo_r, pyo_r;
  assign px  = sx[XW+FRAC_BITS-1:FRAC_BITS];
  assign py  = sy[YW+FRAC_BITS-1:FRAC_BITS];
  assign px1 = px + XW'(1);
  assign py1 = py + YW'(1);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BC = 1'(b % 2);
    localparam logic BR = 1'(b / 2);
    logic [BXW-1:0] rc;
    logic [BYW-1:0] rr;
    assign rc = (px[0] == BC) ? px[XW-1:1] : px1[XW-1:1];
    assign rr = (py[0] == BR) ? py[YW-1:1] : py1[YW-1:1];
    bhs_ram #(.WIDTH(8), .DEPTH(BD)) u_ram (
      .clk(clk),
      .we(pipe_en && wv_r[1] && wcol[0] == BC && wrow[0] == BR),
      .waddr(BAW'({wrow[YW-1:1], wcol[XW-1:1]})),
      .wdata(wd2_r),
      .re(pipe_en),
      .raddr(BAW'({rr, rc})),
      .rdata(bank_q[b]));
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      wx_r  <= sx[FRAC_BITS-1:0];
      wy_r  <= sy[FRAC_BITS-1:0];
      pxo_r <= px[0];
      pyo_r <= py[0];
    end
  end

  // stage 4: select neighbours, horizontal blend
  logic [7:0] t00, t10, t01, t11;
  logic [8+FRAC_BITS:0] h0_r, h1_r;
  always_comb begin
    t00 = bank_q[{pyo_r, pxo_r}];
    t10 = bank_q[{pyo_r, ~pxo_r}];
    t01 = bank_q[{~pyo_r, pxo_r}];
    t11 = bank_q[{~pyo_r, ~pxo_r}];
  end
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      h0_r  <= (9+FRAC_BITS)'(t00 * (ONE - wx_r)) + (9+FRAC_BITS)'(t10 * wx_r);
      h1_r  <= (9+FRAC_BITS)'(t01 * (ONE - wx_r)) + (9+FRAC_BITS)'(t11 * wx_r);
      wy2_r <= wy_r;
    end
  end

  // stage 5: vertical blend into output register
  logic [SUMW-1:0] sum;
  assign sum = SUMW'(h0_r * (ONE - wy2_r)) + SUMW'(h1_r * wy2_r);
  always_ff @(posedge clk) begin
    if (pipe_en) out_tdata <= 16'(sum >> (2 * FRAC_BITS - 8));
  end
  assign out_tvalid = v_r[4];

  `BHS_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BHS_ASSERT_IMP(a_stall, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  `BHS_ASSERT_NXT(a_wr_nores, clk, rst_n, pipe_en && !(acc && in_tuser == REQ_QUERY), !v_r[0])
endmodule
